FILE: hw/rtl/cblm_pkg.sv
`default_nettype none

package cblm_pkg;

  localparam int unsigned IdxWidth   = 10;
  localparam int unsigned CfgWidth   = 11;
  localparam int unsigned ValWidth   = 32;
  localparam int unsigned CfgReset   = 1024;

  typedef enum logic [1:0] {
    OP_INCR    = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef struct packed {
    logic [ValWidth-1:0] value;
    logic [ValWidth-1:0] maximum;
    logic                ignored;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/counter_bank_lazy_max.sv
// Bank of saturating event counters with a lazily applied set-all-to-maximum.
// Input stream (s_axis_*): tuser carries the operation (increment, set-all,
// read), tdata the counter index. Output stream (m_axis_*): one result item
// per input item; tdata carries the counter value and the running maximum,
// tuser flags an index outside the active counters.
// cfg_we_i/cfg_wdata_i write the number of active counters; write only while
// no item is in flight.
// Path: the accepting edge loads the synchronous read of the counter memory
// into the modify stage; when that stage advances, the modify/write-back
// result is loaded into the output register.
// Throughput: one item per cycle unless stalled or clearing; the write-back
// that the next item reads is forwarded: one memory read and write per cycle suffice.
// Reset: floor and maximum clear at once, then a clearing pass writes zero to
// every memory entry, one per cycle; s_axis_tready stays low during that pass.
// Stall: while m_axis_tready is low the output register holds its item, one
// more item may wait in the write-back stage, and s_axis_tready drops.
`default_nettype none

module counter_bank_lazy_max #(
  parameter int unsigned MAX_COUNTERS = 1024,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,   // counters_in_use
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [9:0] counter_index, [15:10] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [31:0] counter_value, [63:32] current_maximum
  output logic             m_axis_tuser   // [0] index_ignored
);

  localparam int unsigned AddrWidth = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(MAX_COUNTERS - 1);
  localparam logic [COUNT_WIDTH-1:0] TopValue = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] mem [MAX_COUNTERS];

  logic [cblm_pkg::CfgWidth-1:0] cfg_q;
  logic                          clr_q, clr_d;
  logic [AddrWidth-1:0]          clr_addr_q, clr_addr_d;

  logic                          s1_v_q, s1_v_d;
  cblm_pkg::op_e                 s1_op_q;
  logic                          s1_ign_q;
  logic [AddrWidth-1:0]          s1_addr_q;
  logic [COUNT_WIDTH-1:0]        rd_q;
  logic                          fwd_q;
  logic [COUNT_WIDTH-1:0]        fwd_val_q;

  logic [COUNT_WIDTH-1:0]        floor_q, floor_d;
  logic [COUNT_WIDTH-1:0]        max_q, max_d;

  logic                          out_v_q, out_v_d;
  cblm_pkg::result_t             out_q;

  logic                          in_acc;
  logic                          s1_adv;
  logic [cblm_pkg::IdxWidth-1:0] in_idx;
  cblm_pkg::op_e                 in_op;
  logic                          in_ign;
  logic [AddrWidth-1:0]          in_addr;

  logic [COUNT_WIDTH-1:0]        base_val;
  logic [COUNT_WIDTH-1:0]        lift_val;
  logic [COUNT_WIDTH-1:0]        inc_val;
  logic                          s1_we;
  cblm_pkg::result_t             res;

  logic                          mem_we;
  logic [AddrWidth-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0]        mem_wdata;

  assign in_idx  = s_axis_tdata[cblm_pkg::IdxWidth-1:0];
  assign in_op   = cblm_pkg::op_e'(s_axis_tuser);
  assign in_addr = AddrWidth'(in_idx);
  assign in_ign  = ({1'b0, in_idx} >= cfg_q) || (32'(in_idx) >= 32'(MAX_COUNTERS));

  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !clr_q && (!s1_v_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Modify stage
  always_comb begin
    base_val = fwd_q ? fwd_val_q : rd_q;
    lift_val = (base_val < floor_q) ? floor_q : base_val;
    inc_val  = (lift_val == TopValue) ? lift_val : lift_val + 1'b1;
  end

  always_comb begin
    s1_we       = 1'b0;
    floor_d     = floor_q;
    max_d       = max_q;
    res.value   = '0;
    res.ignored = 1'b0;
    unique case (s1_op_q)
      cblm_pkg::OP_INCR: begin
        if (s1_ign_q) begin
          res.ignored = 1'b1;
        end else begin
          s1_we     = s1_adv;
          res.value = cblm_pkg::ValWidth'(inc_val);
          if (inc_val > max_q) begin
            max_d = inc_val;
          end
        end
      end
      cblm_pkg::OP_SET_ALL: begin
        floor_d   = max_q;
        res.value = cblm_pkg::ValWidth'(max_q);
      end
      cblm_pkg::OP_READ: begin
        if (s1_ign_q) begin
          res.ignored = 1'b1;
        end else begin
          res.value = cblm_pkg::ValWidth'(lift_val);
        end
      end
      default: begin
      end
    endcase
    res.maximum = cblm_pkg::ValWidth'(max_d);
  end

  // Control next state
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
    s1_v_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_q);
    out_v_d = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_q);
  end

  always_comb begin
    mem_we    = clr_q || s1_we;
    mem_waddr = clr_q ? clr_addr_q : s1_addr_q;
    mem_wdata = clr_q ? '0 : inc_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= cblm_pkg::CfgWidth'(cblm_pkg::CfgReset);
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      floor_q    <= '0;
      max_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s1_v_q     <= s1_v_d;
      out_v_q    <= out_v_d;
      if (s1_adv) begin
        floor_q <= floor_d;
        max_q   <= max_d;
      end
    end
  end

  // Stage and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_op;
      s1_ign_q  <= in_ign;
      s1_addr_q <= in_addr;
      fwd_q     <= s1_we && (s1_addr_q == in_addr);
      fwd_val_q <= inc_val;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= mem[in_addr];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.maximum, out_q.value};
  assign m_axis_tuser  = out_q.ignored;

  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_q |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  a_no_commit_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_we |-> !clr_q)
    else $error("counter write-back during clearing pass");

  a_floor_below_max: assert property (
    @(posedge clk_i) disable iff (!rst_ni) floor_q <= max_q)
    else $error("floor above running maximum");

  a_max_covers_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_we |=> max_q >= $past(inc_val))
    else $error("running maximum below a written counter");

  a_clear_continues: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (clr_q && clr_addr_q != LastAddr) |=> clr_q)
    else $error("clearing pass ended early");

endmodule

`default_nettype wire
